/* hw/rtl/imm_pkg.sv */
package imm_pkg;

    localparam int DATA_W      = 32;
    localparam int CFG_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int OUT_IDX_W   = 3;
    localparam int MAX_DIM_DEF = 8;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_FIRST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_SECOND = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_SECOND = 2'd3;

    typedef enum logic [1:0] {
        S_LOAD,
        S_FEED,
        S_DRAIN,
        S_EMIT
    } state_t;

endpackage

/* hw/rtl/imm_ram.sv */
module imm_ram #(
    parameter int WIDTH = imm_pkg::DATA_W,
    parameter int DEPTH = imm_pkg::MAX_DIM_DEF * imm_pkg::MAX_DIM_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/imm_cell.sv */
module imm_cell #(
    parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF,
    localparam int K_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    localparam int W = imm_pkg::DATA_W
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [W-1:0]   a_in,
    input  logic [K_W-1:0] k_in,
    input  logic           v_in,
    output logic [W-1:0]   a_out,
    output logic [K_W-1:0] k_out,
    output logic           v_out,
    input  logic           wr_en,
    input  logic [K_W-1:0] wr_k,
    input  logic [W-1:0]   wr_data,
    input  logic           clr,
    output logic [W-1:0]   acc
);

    // one column of the second matrix, indexed by k
    logic [W-1:0]   b_mem_reg [MAX_DIM];
    logic [W-1:0]   a_reg;
    logic [K_W-1:0] k_reg;
    logic           v_reg;
    logic [W-1:0]   prod_reg;
    logic           pv_reg;
    logic [W-1:0]   acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= 1'b0;
            pv_reg <= 1'b0;
        end
        else
        begin
            v_reg  <= v_in;
            pv_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_in;
        k_reg    <= k_in;
        prod_reg <= a_in * b_mem_reg[k_in];
        if (wr_en)
        begin
            b_mem_reg[wr_k] <= wr_data;
        end
        if (clr)
        begin
            acc_reg <= '0;
        end
        else if (pv_reg)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    assign a_out = a_reg;
    assign k_out = k_reg;
    assign v_out = v_reg;
    assign acc   = acc_reg;

endmodule

/* hw/rtl/integer_matrix_multiply.sv */
// channel   signals                                        direction
// input     in_valid, in_ready, element                    item in
// output    out_valid, out_ready, product, row_index,      item out
//           col_index, last_flag, error_flag
// config    cfg_we, cfg_index, cfg_data                    write only
//
// an element is taken when in_valid and in_ready are both high; the item with
// the last element of the second matrix starts the product, which output stalls
// can lengthen: per row, the first matrix row streams from the ram through the
// chain of column cells, drains, then the row is emitted one item a cycle while
// the output is not stalled.
// reset clears dimensions to 8 and the load position; stores are not cleared.
// a stalled output holds the emit sequence; input is taken only while loading.
module integer_matrix_multiply #(
    parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [imm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [imm_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [imm_pkg::DATA_W-1:0]  element,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [imm_pkg::DATA_W-1:0]  product,
    output logic [imm_pkg::OUT_IDX_W-1:0] row_index,
    output logic [imm_pkg::OUT_IDX_W-1:0] col_index,
    output logic                          last_flag,
    output logic                          error_flag
);

    localparam int W      = imm_pkg::DATA_W;
    localparam int CW     = imm_pkg::CFG_W;
    localparam int OIW    = imm_pkg::OUT_IDX_W;
    localparam int K_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    imm_pkg::state_t state_reg, state_next;

    logic [CW-1:0] rows_first_reg, cols_first_reg, rows_second_reg, cols_second_reg;
    logic [DIM_W-1:0] m_eff, n_eff, p_eff, q_eff;
    logic [DIM_W-1:0] m_last, n_last, q_last;
    logic dim_err;

    logic              phase_reg;
    logic [ADDR_W-1:0] a_addr_reg;
    logic [K_W-1:0]    a_row_reg, a_col_reg;
    logic [K_W-1:0]    b_k_reg, b_j_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [K_W-1:0]    f_k_reg;
    logic [DIM_W-1:0]  drain_reg;
    logic [K_W-1:0]    row_reg, col_reg;
    logic              v_d_reg;
    logic [K_W-1:0]    k_d_reg;

    logic out_valid_reg;
    logic [W-1:0]   out_product_reg;
    logic [OIW-1:0] out_row_reg, out_col_reg;
    logic out_last_reg, out_err_reg;

    logic in_fire, ld_a, ld_b, err_fire, last_load, start_run;
    logic feed_last, drain_done, emit_fire, row_done, run_done, clr;
    logic out_free;

    logic [W-1:0] ram_rdata;
    logic [W-1:0]   a_link [MAX_DIM];
    logic [K_W-1:0] k_link [MAX_DIM];
    logic           v_link [MAX_DIM];
    logic [W-1:0]   acc_q  [MAX_DIM];

    always_comb
    begin
        m_eff = (rows_first_reg == '0) ? DIM_W'(1) :
                (32'(rows_first_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(rows_first_reg);
        n_eff = (cols_first_reg == '0) ? DIM_W'(1) :
                (32'(cols_first_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(cols_first_reg);
        p_eff = (rows_second_reg == '0) ? DIM_W'(1) :
                (32'(rows_second_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(rows_second_reg);
        q_eff = (cols_second_reg == '0) ? DIM_W'(1) :
                (32'(cols_second_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(cols_second_reg);
    end

    assign m_last  = m_eff - DIM_W'(1);
    assign n_last  = n_eff - DIM_W'(1);
    assign q_last  = q_eff - DIM_W'(1);
    assign dim_err = (n_eff != p_eff);

    // head cell sums its last term once the last feed passes the ram read register and its product register
    assign out_free   = !out_valid_reg || out_ready;
    assign last_load  = phase_reg && (DIM_W'(b_j_reg) == q_last) && (DIM_W'(b_k_reg) == n_last);
    assign feed_last  = (DIM_W'(f_k_reg) == n_last);
    assign drain_done = (drain_reg == DIM_W'(1));
    assign row_done   = (DIM_W'(col_reg) == q_last);
    assign run_done   = row_done && (DIM_W'(row_reg) == m_last);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            imm_pkg::S_LOAD:
            begin
                if (in_valid && out_free && !dim_err && last_load)
                begin
                    state_next = imm_pkg::S_FEED;
                end
            end
            imm_pkg::S_FEED:
            begin
                if (feed_last)
                begin
                    state_next = imm_pkg::S_DRAIN;
                end
            end
            imm_pkg::S_DRAIN:
            begin
                if (drain_done)
                begin
                    state_next = imm_pkg::S_EMIT;
                end
            end
            imm_pkg::S_EMIT:
            begin
                if (out_free && row_done)
                begin
                    state_next = run_done ? imm_pkg::S_LOAD : imm_pkg::S_FEED;
                end
            end
            default:
            begin
                state_next = imm_pkg::S_LOAD;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready  = 1'b0;
        emit_fire = 1'b0;
        clr       = 1'b0;
        unique case (state_reg)
            imm_pkg::S_LOAD:
            begin
                in_ready = out_free;
            end
            imm_pkg::S_FEED:
            begin
                clr = (f_k_reg == '0);
            end
            imm_pkg::S_DRAIN:
            begin
                clr = 1'b0;
            end
            imm_pkg::S_EMIT:
            begin
                emit_fire = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign in_fire   = in_valid && in_ready;
    assign err_fire  = in_fire && dim_err;
    assign ld_a      = in_fire && !dim_err && !phase_reg;
    assign ld_b      = in_fire && !dim_err && phase_reg;
    assign start_run = ld_b && last_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= imm_pkg::S_LOAD;
            rows_first_reg  <= imm_pkg::CFG_RESET;
            cols_first_reg  <= imm_pkg::CFG_RESET;
            rows_second_reg <= imm_pkg::CFG_RESET;
            cols_second_reg <= imm_pkg::CFG_RESET;
            phase_reg       <= 1'b0;
            a_addr_reg      <= '0;
            a_row_reg       <= '0;
            a_col_reg       <= '0;
            b_k_reg         <= '0;
            b_j_reg         <= '0;
            rd_addr_reg     <= '0;
            f_k_reg         <= '0;
            drain_reg       <= '0;
            row_reg         <= '0;
            col_reg         <= '0;
            v_d_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v_d_reg   <= (state_reg == imm_pkg::S_FEED);

            if (cfg_we)
            begin
                unique case (cfg_index)
                    imm_pkg::REG_ROWS_FIRST:  rows_first_reg  <= cfg_data;
                    imm_pkg::REG_COLS_FIRST:  cols_first_reg  <= cfg_data;
                    imm_pkg::REG_ROWS_SECOND: rows_second_reg <= cfg_data;
                    imm_pkg::REG_COLS_SECOND: cols_second_reg <= cfg_data;
                    default:                  rows_first_reg  <= rows_first_reg;
                endcase
                phase_reg  <= 1'b0;
                a_addr_reg <= '0;
                a_row_reg  <= '0;
                a_col_reg  <= '0;
                b_k_reg    <= '0;
                b_j_reg    <= '0;
            end
            else if (ld_a)
            begin
                a_addr_reg <= a_addr_reg + ADDR_W'(1);
                if (DIM_W'(a_col_reg) == n_last)
                begin
                    a_col_reg <= '0;
                    if (DIM_W'(a_row_reg) == m_last)
                    begin
                        a_row_reg <= '0;
                        phase_reg <= 1'b1;
                    end
                    else
                    begin
                        a_row_reg <= a_row_reg + K_W'(1);
                    end
                end
                else
                begin
                    a_col_reg <= a_col_reg + K_W'(1);
                end
            end
            else if (ld_b)
            begin
                if (DIM_W'(b_j_reg) == q_last)
                begin
                    b_j_reg <= '0;
                    if (DIM_W'(b_k_reg) == n_last)
                    begin
                        b_k_reg    <= '0;
                        phase_reg  <= 1'b0;
                        a_addr_reg <= '0;
                    end
                    else
                    begin
                        b_k_reg <= b_k_reg + K_W'(1);
                    end
                end
                else
                begin
                    b_j_reg <= b_j_reg + K_W'(1);
                end
            end

            if (start_run)
            begin
                rd_addr_reg <= '0;
                f_k_reg     <= '0;
                row_reg     <= '0;
                col_reg     <= '0;
            end

            if (state_reg == imm_pkg::S_FEED)
            begin
                rd_addr_reg <= rd_addr_reg + ADDR_W'(1);
                f_k_reg     <= feed_last ? '0 : f_k_reg + K_W'(1);
                drain_reg   <= '0;
            end

            if (state_reg == imm_pkg::S_DRAIN)
            begin
                drain_reg <= drain_reg + DIM_W'(1);
            end

            if (emit_fire)
            begin
                if (row_done)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + K_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + K_W'(1);
                end
            end

            if (err_fire || emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_d_reg <= f_k_reg;
        if (err_fire)
        begin
            out_product_reg <= '0;
            out_row_reg     <= '0;
            out_col_reg     <= '0;
            out_last_reg    <= 1'b0;
            out_err_reg     <= 1'b1;
        end
        else if (emit_fire)
        begin
            out_product_reg <= acc_q[col_reg];
            out_row_reg     <= OIW'(row_reg);
            out_col_reg     <= OIW'(col_reg);
            out_last_reg    <= run_done;
            out_err_reg     <= 1'b0;
        end
    end

    // first matrix, row-major at linear addresses
    imm_ram #(
        .WIDTH (W),
        .DEPTH (DEPTH)
    ) u_first_ram (
        .clk   (clk),
        .we    (ld_a),
        .waddr (a_addr_reg),
        .wdata (element),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    // cell j holds column j of the second matrix and its product sum
    for (genvar j = 0; j < MAX_DIM; j++)
    begin : g_cell
        logic [W-1:0]   a_src;
        logic [K_W-1:0] k_src;
        logic           v_src;

        if (j == 0)
        begin : g_head
            assign a_src = ram_rdata;
            assign k_src = k_d_reg;
            assign v_src = v_d_reg;
        end
        else
        begin : g_tail
            assign a_src = a_link[j-1];
            assign k_src = k_link[j-1];
            assign v_src = v_link[j-1];
        end

        imm_cell #(
            .MAX_DIM (MAX_DIM)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .a_in    (a_src),
            .k_in    (k_src),
            .v_in    (v_src),
            .a_out   (a_link[j]),
            .k_out   (k_link[j]),
            .v_out   (v_link[j]),
            .wr_en   (ld_b && (b_j_reg == K_W'(j))),
            .wr_k    (b_k_reg),
            .wr_data (element),
            .clr     (clr),
            .acc     (acc_q[j])
        );
    end

    assign out_valid  = out_valid_reg;
    assign product    = out_product_reg;
    assign row_index  = out_row_reg;
    assign col_index  = out_col_reg;
    assign last_flag  = out_last_reg;
    assign error_flag = out_err_reg;

endmodule
